@@ design/srt_pkg.sv @@
// shared types, constants and codes for the sparse radix table
`timescale 1ns / 1ps
package srt_pkg;

  localparam int unsigned FANOUT     = 16;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_LEVELS = 4;
  localparam int unsigned NODE_COUNT = 256;
  localparam int unsigned NODE_W     = 8;
  localparam int unsigned NFREE_W    = 9;
  localparam int unsigned LEV_W      = 3;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned ADDR_W     = NODE_W + DIGIT_W;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [15:0]        index;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic               status;
    logic [3:0]         leaf_offset;
    logic [2:0]         levels_now;
  } out_t;

  // classified command passed from front to back
  typedef struct packed {
    in_t              item;
    logic [LEV_W-1:0] need;
  } cmd_t;

endpackage

@@ design/srt_front.sv @@
// front part: accepts beats and works out how many levels the index needs
`timescale 1ns / 1ps
module srt_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  srt_pkg::in_t  in_data_i,
  output logic          push_o,
  input  logic          full_i,
  output srt_pkg::cmd_t cmd_o
);

  logic [srt_pkg::LEV_W-1:0] need;

  // levels needed: count of significant hex digits, at least one
  always_comb begin
    priority if (in_data_i.index[15:12] != 4'd0) begin
      need = 3'd4;
    end else if (in_data_i.index[11:8] != 4'd0) begin
      need = 3'd3;
    end else if (in_data_i.index[7:4] != 4'd0) begin
      need = 3'd2;
    end else begin
      need = 3'd1;
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign cmd_o.item = in_data_i;
  assign cmd_o.need = need;

endmodule

@@ design/srt_queue.sv @@
// short command queue between front and back
`timescale 1ns / 1ps
module srt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  srt_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output srt_pkg::cmd_t pop_data_o
);

  srt_pkg::cmd_t slot_q [srt_pkg::QUEUE_DEPTH];
  logic          wptr_q, wptr_d;
  logic          rptr_q, rptr_d;
  logic [1:0]    cnt_q, cnt_d;

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = slot_q[rptr_q];

endmodule

@@ design/srt_back.sv @@
// back part: node store, tree growth, walk, allocation and result register
`timescale 1ns / 1ps
module srt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          pop_o,
  input  srt_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output srt_pkg::out_t out_data_o
);

  typedef enum logic [7:0] {
    S_ZERO  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_GROW  = 8'b0000_0100,
    S_WALK  = 8'b0000_1000,
    S_CHECK = 8'b0001_0000,
    S_LINK  = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_e;

  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_GROW = 2'd1,
    MODE_WALK = 2'd2
  } mode_e;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic               status;
    logic [3:0]         leaf_offset;
  } res_t;

  state_e                      state_q, state_d;
  mode_e                       mode_q, mode_d;
  logic [srt_pkg::NODE_W-1:0]  zn_q, zn_d;
  logic [srt_pkg::DIGIT_W-1:0] zc_q, zc_d;
  logic [srt_pkg::NODE_W-1:0]  node_q, node_d;
  logic [srt_pkg::LEV_W-1:0]   lev_q, lev_d;
  srt_pkg::cmd_t               cmd_q, cmd_d;
  logic [srt_pkg::NODE_W-1:0]  root_q, root_d;
  logic [srt_pkg::LEV_W-1:0]   levels_q, levels_d;
  logic [srt_pkg::NFREE_W-1:0] nf_q, nf_d;
  res_t                        res_q, res_d;
  logic                        out_valid_q, out_valid_d;
  srt_pkg::out_t               out_q, out_d;

  logic [srt_pkg::WORD_W-1:0]  mem_q [srt_pkg::NODE_COUNT * srt_pkg::FANOUT];
  logic [srt_pkg::WORD_W-1:0]  rdata_q;
  logic                        we;
  logic [srt_pkg::ADDR_W-1:0]  addr;
  logic [srt_pkg::WORD_W-1:0]  wdata;

  logic [srt_pkg::DIGIT_W-1:0] digit;
  logic [4:0]                  shamt;
  logic                        link_ok;
  logic [srt_pkg::NFREE_W-1:0] link_w;
  logic [srt_pkg::NFREE_W-1:0] root_link;
  logic [srt_pkg::NFREE_W-1:0] nf_link;
  logic                        pool_empty;
  res_t                        fail_res;

  // digit of the index at the current level
  assign shamt   = {lev_q - 3'd1, 2'b00};
  assign digit   = srt_pkg::DIGIT_W'(cmd_q.item.index >> shamt);

  // child link decode: node number plus one, zero or out of range is absent
  assign link_w  = rdata_q[srt_pkg::NFREE_W-1:0];
  assign link_ok = (rdata_q[srt_pkg::WORD_W-1:srt_pkg::NFREE_W] == '0) &&
                   (link_w != '0) &&
                   (link_w <= srt_pkg::NFREE_W'(srt_pkg::NODE_COUNT));

  assign root_link  = {1'b0, root_q} + 9'd1;
  assign nf_link    = nf_q + 9'd1;
  assign pool_empty = (nf_q >= srt_pkg::NFREE_W'(srt_pkg::NODE_COUNT));

  assign fail_res.read_data   = '0;
  assign fail_res.status      = srt_pkg::ST_FAIL;
  assign fail_res.leaf_offset = '0;

  // sequencer
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    zn_d        = zn_q;
    zc_d        = zc_q;
    node_d      = node_q;
    lev_d       = lev_q;
    cmd_d       = cmd_q;
    root_d      = root_q;
    levels_d    = levels_q;
    nf_d        = nf_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    addr        = {node_q, digit};
    wdata       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      // zero-fill one node, linking the old root on growth
      S_ZERO: begin
        we    = 1'b1;
        addr  = {zn_q, zc_q};
        wdata = (mode_q == MODE_GROW && zc_q == '0) ?
                srt_pkg::WORD_W'(root_link) : '0;
        if (zc_q == '1) begin
          unique case (mode_q)
            MODE_INIT: state_d = S_IDLE;
            MODE_GROW: begin
              root_d   = zn_q;
              levels_d = levels_q + 3'd1;
              nf_d     = nf_q + 9'd1;
              state_d  = S_GROW;
            end
            MODE_WALK: begin
              node_d  = zn_q;
              lev_d   = lev_q - 3'd1;
              nf_d    = nf_q + 9'd1;
              state_d = S_WALK;
            end
            default: state_d = S_IDLE;
          endcase
        end else begin
          zc_d = zc_q + 4'd1;
        end
      end
      S_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          if (cmd_i.item.opcode == srt_pkg::OP_WRITE) begin
            state_d = S_GROW;
          end else if (cmd_i.need > levels_q) begin
            res_d   = '0;
            state_d = S_DONE;
          end else begin
            node_d  = root_q;
            lev_d   = levels_q;
            state_d = S_WALK;
          end
        end
      end
      // add levels on top until the index fits, or fail when the pool is spent
      S_GROW: begin
        if (levels_q < cmd_q.need) begin
          if (pool_empty) begin
            res_d   = fail_res;
            state_d = S_DONE;
          end else begin
            zn_d    = nf_q[srt_pkg::NODE_W-1:0];
            zc_d    = '0;
            mode_d  = MODE_GROW;
            state_d = S_ZERO;
          end
        end else begin
          node_d  = root_q;
          lev_d   = levels_q;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (lev_q == 3'd1) begin
          addr = {node_q, cmd_q.item.index[3:0]};
          if (cmd_q.item.opcode == srt_pkg::OP_WRITE) begin
            we                = 1'b1;
            wdata             = cmd_q.item.value;
            res_d.read_data   = '0;
            res_d.status      = srt_pkg::ST_OK;
            res_d.leaf_offset = cmd_q.item.index[3:0];
            state_d           = S_DONE;
          end else begin
            state_d = S_CHECK;
          end
        end else begin
          state_d = S_CHECK;
        end
      end
      // registered read word is here
      S_CHECK: begin
        if (lev_q == 3'd1) begin
          res_d.read_data   = rdata_q;
          res_d.status      = srt_pkg::ST_OK;
          res_d.leaf_offset = '0;
          state_d           = S_DONE;
        end else if (link_ok) begin
          node_d  = srt_pkg::NODE_W'(link_w - 9'd1);
          lev_d   = lev_q - 3'd1;
          state_d = S_WALK;
        end else if (cmd_q.item.opcode == srt_pkg::OP_READ) begin
          res_d   = '0;
          state_d = S_DONE;
        end else if (pool_empty) begin
          res_d   = fail_res;
          state_d = S_DONE;
        end else begin
          state_d = S_LINK;
        end
      end
      // store the link to the new child, then zero it
      S_LINK: begin
        we      = 1'b1;
        wdata   = srt_pkg::WORD_W'(nf_link);
        zn_d    = nf_q[srt_pkg::NODE_W-1:0];
        zc_d    = '0;
        mode_d  = MODE_WALK;
        state_d = S_ZERO;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.read_data   = res_q.read_data;
          out_d.status      = res_q.status;
          out_d.leaf_offset = res_q.leaf_offset;
          out_d.levels_now  = levels_q;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ZERO;
      mode_q      <= MODE_INIT;
      zn_q        <= '0;
      zc_q        <= '0;
      root_q      <= '0;
      levels_q    <= 3'd1;
      nf_q        <= 9'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      zn_q        <= zn_d;
      zc_q        <= zc_d;
      root_q      <= root_d;
      levels_q    <= levels_d;
      nf_q        <= nf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    lev_q  <= lev_d;
    cmd_q  <= cmd_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // node store, single port with registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[addr] <= wdata;
    end
    rdata_q <= mem_q[addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/sparse_radix_table.sv @@
// top level of the sparse radix table
`timescale 1ns / 1ps
// Sparse array of signed 32-bit words kept as a radix tree of 16-slot nodes.
// Input channel (in_valid_i / in_ready_o / in_data_i): one beat per read or
// write command; the front takes beats into a two-entry queue.
// Output channel (out_valid_o / out_ready_i / out_data_o): exactly one result
// beat per command, in command order, held in an output register.
// The back works on one command at a time with a single-port node store:
// a read follows one child link per tree level; a write walks the same way
// and allocates each missing node with a link write and a zero fill of its
// 16 slots; a growing root is allocated by zero fill alone.
// After reset the block clears the root node before it takes commands; the
// tree holds one level and no stored words.
// When the receiver stalls, the result stays in the output register and the
// next command runs up to its result; then the back waits, and the queue
// fills and drops in_ready_o.
module sparse_radix_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  srt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output srt_pkg::out_t out_data_o
);

  logic          push;
  logic          full;
  logic          pop;
  logic          q_valid;
  srt_pkg::cmd_t push_cmd;
  srt_pkg::cmd_t pop_cmd;

  // classify incoming beats
  srt_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .full_i     (full),
    .cmd_o      (push_cmd)
  );

  // decoupling queue
  srt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_cmd)
  );

  // execute against the node store
  srt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .pop_o       (pop),
    .cmd_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ tb/srt_checker.sv @@
// channel monitor, tree predictor and result comparator for the sparse radix table
`timescale 1ns / 1ps
module srt_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  srt_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  srt_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            failed_writes_o
);

  localparam int unsigned STORE_WORDS = srt_pkg::NODE_COUNT * srt_pkg::FANOUT;

  // shadow copy of the tree
  logic [srt_pkg::WORD_W-1:0]  tree_words [STORE_WORDS];
  logic [srt_pkg::NODE_W-1:0]  root_q;
  logic [srt_pkg::LEV_W-1:0]   levels_q;
  logic [srt_pkg::NFREE_W-1:0] free_q;

  srt_pkg::out_t result_fifo [$];

  // FANOUT^n, saturating past the index range
  function automatic int unsigned child_span(int unsigned n);
    int unsigned s;
    s = 1;
    for (int unsigned k = 0; k < n && s <= 16'hFFFF; k++) s = s * srt_pkg::FANOUT;
    return s;
  endfunction

  function automatic bit link_ok(logic [srt_pkg::WORD_W-1:0] w);
    return (w != 0) && (w <= srt_pkg::NODE_COUNT);
  endfunction

  // bump allocator, returns node plus one or zero when the pool is spent
  function automatic int unsigned grab_node();
    int unsigned n;
    if (free_q >= srt_pkg::NODE_COUNT) return 0;
    n = free_q;
    free_q = srt_pkg::NFREE_W'(free_q + 1);
    for (int unsigned k = 0; k < srt_pkg::FANOUT; k++) begin
      tree_words[n*srt_pkg::FANOUT+k] = '0;
    end
    return n + 1;
  endfunction

  function automatic bit tree_write(int unsigned ix, logic [31:0] val,
                                    output logic [3:0] off);
    int unsigned need, node, nn, span, digit, w;
    off = '0;
    need = 1;
    while (ix >= child_span(need)) need++;
    if (need > srt_pkg::MAX_LEVELS) return 0;
    // grow upward, old root becomes child zero
    while (levels_q < need) begin
      nn = grab_node();
      if (nn == 0) return 0;
      tree_words[(nn-1)*srt_pkg::FANOUT] = srt_pkg::WORD_W'(root_q + 1);
      root_q = srt_pkg::NODE_W'(nn - 1);
      levels_q = srt_pkg::LEV_W'(levels_q + 1);
    end
    node = root_q;
    // walk down, allocating missing children
    for (int unsigned lev = levels_q; lev > 1; lev--) begin
      span = child_span(lev - 1);
      digit = ix / span;
      ix = ix % span;
      if (digit >= srt_pkg::FANOUT) return 0;
      w = tree_words[node*srt_pkg::FANOUT+digit];
      if (!link_ok(w)) begin
        w = grab_node();
        if (w == 0) return 0;
        tree_words[node*srt_pkg::FANOUT+digit] = w;
      end
      node = w - 1;
    end
    if (ix >= srt_pkg::FANOUT) return 0;
    tree_words[node*srt_pkg::FANOUT+ix] = val;
    off = ix[3:0];
    return 1;
  endfunction

  function automatic logic [31:0] tree_read(int unsigned ix);
    int unsigned node, span, digit, w;
    node = root_q;
    if (ix >= child_span(levels_q)) return '0;
    for (int unsigned lev = levels_q; lev > 1; lev--) begin
      span = child_span(lev - 1);
      digit = ix / span;
      ix = ix % span;
      if (digit >= srt_pkg::FANOUT) return '0;
      w = tree_words[node*srt_pkg::FANOUT+digit];
      if (!link_ok(w)) return '0;
      node = w - 1;
    end
    if (ix >= srt_pkg::FANOUT) return '0;
    return tree_words[node*srt_pkg::FANOUT+ix];
  endfunction

  function automatic srt_pkg::out_t predict_result(srt_pkg::in_t it);
    srt_pkg::out_t r;
    logic [3:0] off;
    r = '0;
    if (it.opcode == srt_pkg::OP_WRITE) begin
      if (!tree_write(it.index, it.value, off)) begin
        r.status = srt_pkg::ST_FAIL;
        failed_writes_o++;
      end else begin
        r.leaf_offset = off;
      end
    end else begin
      r.read_data = tree_read(it.index);
    end
    r.levels_now = levels_q;
    return r;
  endfunction

  initial begin
    for (int unsigned k = 0; k < STORE_WORDS; k++) tree_words[k] = '0;
    root_q = '0;
    levels_q = 3'd1;
    free_q = 9'd1;
    fail_count_o = 0;
    failed_writes_o = 0;
    pending_o = 0;
  end

  // watch both channels and compare each result beat
  always @(posedge clk_i) begin
    srt_pkg::out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) result_fifo.push_back(predict_result(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (result_fifo.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result beat %p", $time, out_data_i);
        end else begin
          want = result_fifo.pop_front();
          if (want.read_data !== out_data_i.read_data) begin
            fail_count_o++;
            $display("%0t: read_data expected %0d actual %0d", $time,
                     want.read_data, out_data_i.read_data);
          end
          if (want.status !== out_data_i.status) begin
            fail_count_o++;
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_data_i.status);
          end
          if (want.leaf_offset !== out_data_i.leaf_offset) begin
            fail_count_o++;
            $display("%0t: leaf_offset expected %0d actual %0d", $time,
                     want.leaf_offset, out_data_i.leaf_offset);
          end
          if (want.levels_now !== out_data_i.levels_now) begin
            fail_count_o++;
            $display("%0t: levels_now expected %0d actual %0d", $time,
                     want.levels_now, out_data_i.levels_now);
          end
        end
      end
      pending_o = result_fifo.size();
    end
  end

endmodule

@@ tb/tb_sparse_radix_table.sv @@
// stimulus, clocking and verdict for the sparse radix table
`timescale 1ns / 1ps
module tb_sparse_radix_table;

  localparam int RANDOM_ITEMS = 1130;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  srt_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  srt_pkg::out_t out_data;

  int fail_count, pending, failed_writes;
  int sent = 0;
  int n_reads = 0, n_writes = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  logic [11:0] hot_prefix [8];
  logic [15:0] written_ix [$];

  sparse_radix_table dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  srt_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending),
    .failed_writes_o(failed_writes)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off mid-run
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent >= 600) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 23);
    end
  end

  // offer one beat and hold it until taken
  task automatic send_beat(logic op, logic [15:0] ix, logic [31:0] val);
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, index: ix, value: val};
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    sent++;
    if (op == srt_pkg::OP_WRITE) begin
      n_writes++;
      written_ix.push_back(ix);
    end else begin
      n_reads++;
    end
    // random sender gap
    if (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // stop offering until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    logic        op;
    logic [15:0] ix;
    logic [31:0] val;
    for (int k = 0; k < 8; k++) hot_prefix[k] = 12'($urandom());
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tree, capacity edges, growth, extreme values
    send_beat(srt_pkg::OP_READ, 16'd0, 32'h1234_5678);
    send_beat(srt_pkg::OP_READ, 16'hFFFF, '0);
    send_beat(srt_pkg::OP_READ, 16'd16, '0);
    send_beat(srt_pkg::OP_WRITE, 16'd0, 32'h7FFF_FFFF);
    send_beat(srt_pkg::OP_WRITE, 16'd15, 32'h8000_0000);
    send_beat(srt_pkg::OP_READ, 16'd0, 32'hFFFF_FFFF);
    send_beat(srt_pkg::OP_READ, 16'd15, '0);
    send_beat(srt_pkg::OP_WRITE, 16'd16, 32'hFFFF_FFFF);
    send_beat(srt_pkg::OP_READ, 16'd256, '0);
    send_beat(srt_pkg::OP_WRITE, 16'd300, 32'd1);
    send_beat(srt_pkg::OP_WRITE, 16'hFFFF, 32'h5A5A_A5A5);
    send_beat(srt_pkg::OP_READ, 16'hFFFF, '0);
    send_beat(srt_pkg::OP_READ, 16'hFFFE, '0);
    send_beat(srt_pkg::OP_READ, 16'd4096, '0);
    send_beat(srt_pkg::OP_WRITE, 16'h1234, '0);
    send_beat(srt_pkg::OP_READ, 16'h1234, '0);
    send_beat(srt_pkg::OP_READ, 16'd0, '0);
    send_beat(srt_pkg::OP_WRITE, 16'd0, 32'hDEAD_BEEF);
    send_beat(srt_pkg::OP_READ, 16'd0, '0);

    // random: hot regions first, then wide reads and writes that drain the pool
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 300 && i < 450);
      if (i == 800) wait_drained();
      op = 1'($urandom_range(1));
      val = $urandom();
      if (i < 700 || $urandom_range(3) != 0) begin
        if (op == srt_pkg::OP_READ && written_ix.size() != 0 && $urandom_range(3) != 0)
          ix = written_ix[$urandom_range(written_ix.size() - 1)];
        else
          ix = {hot_prefix[$urandom_range(7)], 4'($urandom())};
      end else begin
        ix = 16'($urandom());
      end
      send_beat(op, ix, val);
    end

    // drain and settle
    wait_drained();
    repeat (200) @(posedge clk);
    $display("covered %0d reads and %0d writes, %0d writes refused",
             n_reads, n_writes, failed_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/srt_pkg.sv
design/srt_front.sv
design/srt_queue.sv
design/srt_back.sv
design/sparse_radix_table.sv
tb/srt_checker.sv
tb/tb_sparse_radix_table.sv
